>>> rtl/core/nmls_pkg.sv
// Package with the scan modes, token kinds, character codes and result type.
`default_nettype none

package nmls_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_ZERO = 3'd1,
        MODE_DEC  = 3'd2,
        MODE_HEX  = 3'd3,
        MODE_FRAC = 3'd4,
        MODE_EXPS = 3'd5,
        MODE_EXPD = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        KIND_INT     = 3'd0,
        KIND_INT64   = 3'd1,
        KIND_FLOAT32 = 3'd2,
        KIND_FLOAT64 = 3'd3,
        KIND_BAD     = 3'd4
    } t_kind;

    typedef struct packed {
        logic        took_last;
        logic        too_large;
        t_kind       lit_kind;
        logic [7:0]  text_length;
        logic [63:0] int_value;
    } t_result;

    localparam logic [63:0] DEC_GUARD     = 64'd1844674407370955161;
    localparam logic [63:0] INT64_MIN_MAG = 64'h8000_0000_0000_0000;
    localparam logic [3:0]  DEC_LAST_OK   = 4'd5;
    localparam logic [7:0]  TEXT_CAP      = 8'd255;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_LO_L  = 8'h6c;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    // Return {valid, nibble} for a hex digit character.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= CH_0 && c <= CH_9) begin
            v = c - CH_0;
            return {1'b1, v[3:0]};
        end
        if (c >= CH_LO_A && c <= CH_LO_F) begin
            v = c - CH_LO_A + 8'd10;
            return {1'b1, v[3:0]};
        end
        if (c >= CH_UP_A && c <= CH_UP_F) begin
            v = c - CH_UP_A + 8'd10;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/number_literal_scanner.sv
// Number literal scanner: input register, single-pass scan logic and result register.
`default_nettype none

// Takes one character request per cycle and reports each finished number literal
// (integer, int64, float32, float64 or bad) with its 64-bit value and saturated length.
// Requests pass the input register; the result of the one that ends a token is registered.
// The sustained rate is one request per clock: the scan step (decimal multiply-by-ten add,
// guard compare, hex shift) is one pass of logic between the input and result registers,
// and only a waiting result that is not taken stalls the input side.
module number_literal_scanner #(
    parameter int TEXT_LIMIT = 255
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] ch
    input  wire         i_s_axis_tlast,   // at_line_end
    input  wire         i_s_axis_tuser,   // [0] start_req
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // [63:0] int_value, [71:64] text_length
    output logic [4:0]  o_m_axis_tuser    // [2:0] lit_kind, [3] too_large, [4] took_last
);

    localparam logic [7:0] CNT_LIM = (TEXT_LIMIT > 255) ? nmls_pkg::TEXT_CAP
                                                       : 8'(TEXT_LIMIT);

    logic              r_in_valid;
    logic [7:0]        r_in_ch;
    logic              r_in_eol;
    logic              r_in_st;

    nmls_pkg::t_mode   r_mode, n_mode;
    logic [63:0]       r_accum, n_accum;
    logic              r_ovf, n_ovf;
    logic [7:0]        r_count, n_count;

    logic              r_out_valid;
    nmls_pkg::t_result r_out, n_out;

    logic              w_adv, w_fire, w_emit;
    logic              w_dig, w_hex_ok, w_sfx;
    logic [3:0]        w_dig_val, w_hex_val;
    logic [4:0]        w_hex;
    logic [7:0]        w_cnt_inc;
    logic [7:0]        w_dig_full;
    logic [63:0]       w_mul10;
    logic              w_bad, w_is_float;

    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign w_fire          = r_in_valid && w_adv;
    assign o_s_axis_tready = !r_in_valid || w_adv;

    assign w_dig      = (r_in_ch >= nmls_pkg::CH_0) && (r_in_ch <= nmls_pkg::CH_9);
    assign w_dig_full = r_in_ch - nmls_pkg::CH_0;
    assign w_dig_val  = w_dig_full[3:0];
    assign w_hex      = nmls_pkg::hex_digit(r_in_ch);
    assign w_hex_ok   = w_hex[4];
    assign w_hex_val  = w_hex[3:0];
    assign w_cnt_inc  = (r_count < CNT_LIM) ? r_count + 8'd1 : r_count;
    assign w_mul10    = (r_accum << 3) + (r_accum << 1) + {60'd0, w_dig_val};
    assign w_is_float = (r_mode == nmls_pkg::MODE_FRAC) || (r_mode == nmls_pkg::MODE_EXPS)
                     || (r_mode == nmls_pkg::MODE_EXPD);
    assign w_bad      = r_ovf || (r_mode != nmls_pkg::MODE_HEX
                                  && r_accum > nmls_pkg::INT64_MIN_MAG);

    always_comb begin
        n_mode  = r_mode;
        n_accum = r_accum;
        n_ovf   = r_ovf;
        n_count = r_count;
        w_emit  = 1'b0;
        w_sfx   = 1'b0;

        if (r_mode != nmls_pkg::MODE_IDLE) begin
            if (r_in_st || r_in_eol) begin
                w_emit = 1'b1;
            end else begin
                unique case (r_mode) inside
                    nmls_pkg::MODE_ZERO, nmls_pkg::MODE_DEC: begin
                        if (w_dig) begin
                            if (!r_ovf) begin
                                if (r_accum > nmls_pkg::DEC_GUARD
                                    || (r_accum == nmls_pkg::DEC_GUARD
                                        && w_dig_val > nmls_pkg::DEC_LAST_OK)) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    n_accum = w_mul10;
                                end
                            end
                            n_mode  = nmls_pkg::MODE_DEC;
                            n_count = w_cnt_inc;
                        end else if (r_mode == nmls_pkg::MODE_ZERO
                                     && (r_in_ch == nmls_pkg::CH_LO_X
                                         || r_in_ch == nmls_pkg::CH_UP_X)) begin
                            n_mode  = nmls_pkg::MODE_HEX;
                            n_count = w_cnt_inc;
                        end else if (r_in_ch == nmls_pkg::CH_DOT) begin
                            n_mode  = nmls_pkg::MODE_FRAC;
                            n_count = w_cnt_inc;
                        end else if (r_in_ch == nmls_pkg::CH_LO_E
                                     || r_in_ch == nmls_pkg::CH_UP_E) begin
                            n_mode  = nmls_pkg::MODE_EXPS;
                            n_count = w_cnt_inc;
                        end else if (r_in_ch == nmls_pkg::CH_LO_L) begin
                            w_emit = 1'b1;
                            w_sfx  = 1'b1;
                        end else begin
                            w_emit = 1'b1;
                        end
                    end
                    nmls_pkg::MODE_HEX: begin
                        if (w_hex_ok) begin
                            if (!r_ovf) begin
                                if (r_accum[63:60] != 4'd0) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    n_accum = {r_accum[59:0], w_hex_val};
                                end
                            end
                            n_count = w_cnt_inc;
                        end else if (r_in_ch == nmls_pkg::CH_LO_L) begin
                            w_emit = 1'b1;
                            w_sfx  = 1'b1;
                        end else begin
                            w_emit = 1'b1;
                        end
                    end
                    nmls_pkg::MODE_FRAC: begin
                        if (w_dig) begin
                            n_count = w_cnt_inc;
                        end else if (r_in_ch == nmls_pkg::CH_LO_E
                                     || r_in_ch == nmls_pkg::CH_UP_E) begin
                            n_mode  = nmls_pkg::MODE_EXPS;
                            n_count = w_cnt_inc;
                        end else if (r_in_ch == nmls_pkg::CH_LO_F) begin
                            w_emit = 1'b1;
                            w_sfx  = 1'b1;
                        end else begin
                            w_emit = 1'b1;
                        end
                    end
                    nmls_pkg::MODE_EXPS: begin
                        if (w_dig || r_in_ch == nmls_pkg::CH_PLUS
                            || r_in_ch == nmls_pkg::CH_MINUS) begin
                            n_mode  = nmls_pkg::MODE_EXPD;
                            n_count = w_cnt_inc;
                        end else if (r_in_ch == nmls_pkg::CH_LO_F) begin
                            w_emit = 1'b1;
                            w_sfx  = 1'b1;
                        end else begin
                            w_emit = 1'b1;
                        end
                    end
                    nmls_pkg::MODE_EXPD: begin
                        if (w_dig) begin
                            n_count = w_cnt_inc;
                        end else if (r_in_ch == nmls_pkg::CH_LO_F) begin
                            w_emit = 1'b1;
                            w_sfx  = 1'b1;
                        end else begin
                            w_emit = 1'b1;
                        end
                    end
                    default: begin
                        n_mode = nmls_pkg::MODE_IDLE;
                    end
                endcase
            end
        end

        // Build the token report from the state before this request.
        n_out.took_last   = w_sfx;
        n_out.text_length = w_sfx ? w_cnt_inc : r_count;
        n_out.too_large   = 1'b0;
        n_out.int_value   = 64'd0;
        if (w_is_float) begin
            n_out.lit_kind = w_sfx ? nmls_pkg::KIND_FLOAT32 : nmls_pkg::KIND_FLOAT64;
        end else if (w_bad) begin
            n_out.lit_kind  = nmls_pkg::KIND_BAD;
            n_out.too_large = 1'b1;
        end else begin
            n_out.lit_kind  = w_sfx ? nmls_pkg::KIND_INT64 : nmls_pkg::KIND_INT;
            n_out.int_value = r_accum;
        end

        if (w_emit) begin
            n_mode  = nmls_pkg::MODE_IDLE;
            n_accum = 64'd0;
            n_ovf   = 1'b0;
            n_count = 8'd0;
        end

        // Open a new literal at a start request on a digit.
        if (r_in_st && !r_in_eol && w_dig) begin
            n_mode  = (r_in_ch == nmls_pkg::CH_0) ? nmls_pkg::MODE_ZERO : nmls_pkg::MODE_DEC;
            n_accum = {60'd0, w_dig_val};
            n_ovf   = 1'b0;
            n_count = 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_ch  <= i_s_axis_tdata;
            r_in_eol <= i_s_axis_tlast;
            r_in_st  <= i_s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= nmls_pkg::MODE_IDLE;
            r_accum <= 64'd0;
            r_ovf   <= 1'b0;
            r_count <= 8'd0;
        end else if (w_fire) begin
            r_mode  <= n_mode;
            r_accum <= n_accum;
            r_ovf   <= n_ovf;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_fire && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.text_length, r_out.int_value};
    assign o_m_axis_tuser  = {r_out.took_last, r_out.too_large, r_out.lit_kind};

    a_float_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.lit_kind == nmls_pkg::KIND_FLOAT32
                        || r_out.lit_kind == nmls_pkg::KIND_FLOAT64)
        |-> r_out.int_value == 64'd0 && !r_out.too_large)
        else $error("float token carries an integer value");

    a_bad_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.too_large == (r_out.lit_kind == nmls_pkg::KIND_BAD))
        else $error("too_large disagrees with token kind");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == nmls_pkg::MODE_IDLE |-> r_count == 8'd0 && r_accum == 64'd0 && !r_ovf)
        else $error("idle scanner holds token state");

    a_emit_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_emit |=> r_out_valid)
        else $error("finished token not presented");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_LIM && (!r_out_valid || r_out.text_length != 8'd0))
        else $error("length out of range");

endmodule

`default_nettype wire

>>> tb/number_literal_scanner_monitor.sv
// Monitor for the number literal scanner: predicts each token report and checks results.
module number_literal_scanner_monitor (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [7:0]  i_s_tdata,   // [7:0] ch
    input  wire         i_s_tlast,   // at_line_end
    input  wire         i_s_tuser,   // [0] start_req
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [71:0] i_m_tdata,   // [63:0] int_value, [71:64] text_length
    input  wire  [4:0]  i_m_tuser,   // [2:0] lit_kind, [3] too_large, [4] took_last
    output int          o_fail_count,
    output int          o_pending
);

    nmls_pkg::t_mode   scan_state = nmls_pkg::MODE_IDLE;
    logic [63:0]       value_acc = '0;
    logic              value_overflow = 1'b0;
    logic [7:0]        token_length = '0;
    nmls_pkg::t_result expected_tokens[$];
    int                fails = 0;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= nmls_pkg::CH_0) && (c <= nmls_pkg::CH_9);
    endfunction

    task automatic bump_length();
        if (token_length < nmls_pkg::TEXT_CAP) begin
            token_length = token_length + 8'd1;
        end
    endtask

    task automatic close_token(input logic suffix, input logic took);
        nmls_pkg::t_result r;
        r = '0;
        if (scan_state == nmls_pkg::MODE_FRAC || scan_state == nmls_pkg::MODE_EXPS
            || scan_state == nmls_pkg::MODE_EXPD) begin
            r.lit_kind = suffix ? nmls_pkg::KIND_FLOAT32 : nmls_pkg::KIND_FLOAT64;
        end else if (value_overflow ||
                     (scan_state != nmls_pkg::MODE_HEX
                      && value_acc > nmls_pkg::INT64_MIN_MAG)) begin
            r.lit_kind  = nmls_pkg::KIND_BAD;
            r.too_large = 1'b1;
        end else begin
            r.lit_kind  = suffix ? nmls_pkg::KIND_INT64 : nmls_pkg::KIND_INT;
            r.int_value = value_acc;
        end
        r.text_length = token_length;
        r.took_last   = took;
        expected_tokens.push_back(r);
        scan_state     = nmls_pkg::MODE_IDLE;
        value_acc      = '0;
        value_overflow = 1'b0;
        token_length   = '0;
    endtask

    task automatic add_decimal(input logic [7:0] c);
        logic [7:0] d;
        d = c - nmls_pkg::CH_0;
        if (!value_overflow) begin
            if (value_acc > nmls_pkg::DEC_GUARD
                || (value_acc == nmls_pkg::DEC_GUARD && d[3:0] > nmls_pkg::DEC_LAST_OK)) begin
                value_overflow = 1'b1;
            end else begin
                value_acc = value_acc * 64'd10 + {56'd0, d};
            end
        end
    endtask

    task automatic take_char(input logic [7:0] c);
        logic       keep;
        logic       hex_ok;
        logic [7:0] nib;
        keep   = 1'b1;
        hex_ok = 1'b1;
        nib    = '0;
        if (is_digit(c)) begin
            nib = c - nmls_pkg::CH_0;
        end else if (c >= nmls_pkg::CH_LO_A && c <= nmls_pkg::CH_LO_F) begin
            nib = c - nmls_pkg::CH_LO_A + 8'd10;
        end else if (c >= nmls_pkg::CH_UP_A && c <= nmls_pkg::CH_UP_F) begin
            nib = c - nmls_pkg::CH_UP_A + 8'd10;
        end else begin
            hex_ok = 1'b0;
        end
        case (scan_state) inside
            nmls_pkg::MODE_ZERO, nmls_pkg::MODE_DEC: begin
                if (is_digit(c)) begin
                    add_decimal(c);
                    scan_state = nmls_pkg::MODE_DEC;
                end else if (scan_state == nmls_pkg::MODE_ZERO
                             && (c == nmls_pkg::CH_LO_X || c == nmls_pkg::CH_UP_X)) begin
                    scan_state = nmls_pkg::MODE_HEX;
                end else if (c == nmls_pkg::CH_DOT) begin
                    scan_state = nmls_pkg::MODE_FRAC;
                end else if (c == nmls_pkg::CH_LO_E || c == nmls_pkg::CH_UP_E) begin
                    scan_state = nmls_pkg::MODE_EXPS;
                end else if (c == nmls_pkg::CH_LO_L) begin
                    bump_length();
                    close_token(1'b1, 1'b1);
                    keep = 1'b0;
                end else begin
                    close_token(1'b0, 1'b0);
                    keep = 1'b0;
                end
            end
            nmls_pkg::MODE_HEX: begin
                if (hex_ok) begin
                    if (!value_overflow) begin
                        if (value_acc[63:60] != 4'd0) begin
                            value_overflow = 1'b1;
                        end else begin
                            value_acc = {value_acc[59:0], nib[3:0]};
                        end
                    end
                end else if (c == nmls_pkg::CH_LO_L) begin
                    bump_length();
                    close_token(1'b1, 1'b1);
                    keep = 1'b0;
                end else begin
                    close_token(1'b0, 1'b0);
                    keep = 1'b0;
                end
            end
            nmls_pkg::MODE_FRAC, nmls_pkg::MODE_EXPS, nmls_pkg::MODE_EXPD: begin
                if (is_digit(c) && scan_state != nmls_pkg::MODE_EXPS) begin
                    // stay in fraction or exponent digits
                end else if (scan_state == nmls_pkg::MODE_EXPS &&
                             (is_digit(c) || c == nmls_pkg::CH_PLUS
                              || c == nmls_pkg::CH_MINUS)) begin
                    scan_state = nmls_pkg::MODE_EXPD;
                end else if (scan_state == nmls_pkg::MODE_FRAC
                             && (c == nmls_pkg::CH_LO_E || c == nmls_pkg::CH_UP_E)) begin
                    scan_state = nmls_pkg::MODE_EXPS;
                end else if (c == nmls_pkg::CH_LO_F) begin
                    bump_length();
                    close_token(1'b1, 1'b1);
                    keep = 1'b0;
                end else begin
                    close_token(1'b0, 1'b0);
                    keep = 1'b0;
                end
            end
            default: begin
                keep = 1'b0;
            end
        endcase
        if (keep) begin
            bump_length();
        end
    endtask

    task automatic predict_step(input logic [7:0] c, input logic eol, input logic st);
        if (scan_state != nmls_pkg::MODE_IDLE) begin
            if (st || eol) begin
                close_token(1'b0, 1'b0);
            end else begin
                take_char(c);
            end
        end
        if (st && !eol && scan_state == nmls_pkg::MODE_IDLE && is_digit(c)) begin
            scan_state     = (c == nmls_pkg::CH_0) ? nmls_pkg::MODE_ZERO : nmls_pkg::MODE_DEC;
            value_acc      = {56'd0, c - nmls_pkg::CH_0};
            value_overflow = 1'b0;
            token_length   = 8'd1;
        end
    endtask

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", field, want, got);
            fails++;
        end
    endtask

    task automatic check_result();
        nmls_pkg::t_result want;
        if (expected_tokens.size() == 0) begin
            $error("token result with none expected: tdata %0h tuser %0h",
                   i_m_tdata, i_m_tuser);
            fails++;
        end else begin
            want = expected_tokens.pop_front();
            compare_field("lit_kind", 64'(want.lit_kind), 64'(i_m_tuser[2:0]));
            compare_field("too_large", 64'(want.too_large), 64'(i_m_tuser[3]));
            compare_field("took_last", 64'(want.took_last), 64'(i_m_tuser[4]));
            compare_field("int_value", want.int_value, i_m_tdata[63:0]);
            compare_field("text_length", 64'(want.text_length), 64'(i_m_tdata[71:64]));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scan_state     = nmls_pkg::MODE_IDLE;
            value_acc      = '0;
            value_overflow = 1'b0;
            token_length   = '0;
            expected_tokens.delete();
        end else begin
            // check results before predicting, so a fresh request never matches
            if (i_m_tvalid && i_m_tready) begin
                check_result();
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_step(i_s_tdata, i_s_tlast, i_s_tuser);
            end
        end
        o_pending    = expected_tokens.size();
        o_fail_count = fails;
    end

endmodule

>>> tb/number_literal_scanner_test.sv
// Top of the number literal scanner testbench: clock, reset, character stimulus and verdict.
module number_literal_scanner_test;

    localparam int ITEM_TARGET = 1900;
    localparam int CALM_FROM   = 1600;
    localparam int HOLD_AT     = 700;
    localparam int PAUSE_AT    = 1200;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 600000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data = 8'd0;
    logic        s_last = 1'b0;
    logic        s_user = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b1;
    logic [71:0] m_data;
    logic [4:0]  m_user;

    int fail_count;
    int pending;
    int items_sent = 0;
    int cycle_count = 0;
    int stall_left = 0;
    bit calm = 1'b0;
    bit hold_off_go = 1'b0;
    bit hold_off_seen = 1'b0;
    bit paused = 1'b0;

    string boundary_text [0:10] = '{
        "9223372036854775807", "9223372036854775808", "9223372036854775809",
        "18446744073709551615", "18446744073709551616", "1844674407370955161",
        "99999999999999999999", "0xFFFFFFFFFFFFFFFF", "0x8000000000000000",
        "0x10000000000000000", "0x7fffffffffffffff"
    };

    number_literal_scanner dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    number_literal_scanner_monitor token_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_s_tlast    (s_last),
        .i_s_tuser    (s_user),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .i_m_tuser    (m_user),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off, steady at the end
    initial begin
        forever begin
            @(negedge clk);
            if (hold_off_go && !hold_off_seen) begin
                hold_off_seen = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                m_ready <= 1'b1;
            end else if (calm) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 12) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic logic [7:0] dec_char();
        logic [7:0] v;
        v = 8'($urandom_range(0, 9));
        return nmls_pkg::CH_0 + v;
    endfunction

    function automatic logic [7:0] hex_char();
        logic [7:0] v;
        v = 8'($urandom_range(0, 15));
        if (v < 8'd10) begin
            return nmls_pkg::CH_0 + v;
        end
        return ($urandom_range(0, 1) ? nmls_pkg::CH_LO_A : nmls_pkg::CH_UP_A) + v - 8'd10;
    endfunction

    task automatic push_char(input logic [7:0] c, input logic eol, input logic st,
                             input bit counts);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge clk);
                s_valid <= 1'b0;
            end
        end
        @(negedge clk);
        s_valid <= 1'b1;
        s_data  <= c;
        s_last  <= eol;
        s_user  <= st;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        if (counts) begin
            items_sent++;
        end
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            push_char(s[i], 1'b0, i == 0, 1'b1);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic send_literal(input int pick);
        int    n;
        int    i;
        string s;
        n = 0;
        if (pick < 28) begin
            push_char(dec_char(), 1'b0, 1'b1, 1'b1);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 21) : $urandom_range(0, 5);
            for (i = 0; i < n; i++) push_char(dec_char(), 1'b0, 1'b0, 1'b1);
            if ($urandom_range(0, 3) == 0) push_char(nmls_pkg::CH_LO_L, 1'b0, 1'b0, 1'b1);
        end else if (pick < 48) begin
            push_char(nmls_pkg::CH_0, 1'b0, 1'b1, 1'b1);
            push_char($urandom_range(0, 1) ? nmls_pkg::CH_LO_X : nmls_pkg::CH_UP_X,
                      1'b0, 1'b0, 1'b1);
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 17) : $urandom_range(0, 8);
            for (i = 0; i < n; i++) push_char(hex_char(), 1'b0, 1'b0, 1'b1);
            if ($urandom_range(0, 3) == 0) push_char(nmls_pkg::CH_LO_L, 1'b0, 1'b0, 1'b1);
        end else if (pick < 68) begin
            push_char(dec_char(), 1'b0, 1'b1, 1'b1);
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++) push_char(dec_char(), 1'b0, 1'b0, 1'b1);
            if ($urandom_range(0, 2) != 0) begin
                push_char(nmls_pkg::CH_DOT, 1'b0, 1'b0, 1'b1);
                n = $urandom_range(0, 4);
                for (i = 0; i < n; i++) push_char(dec_char(), 1'b0, 1'b0, 1'b1);
            end
            if ($urandom_range(0, 1) != 0) begin
                push_char($urandom_range(0, 1) ? nmls_pkg::CH_LO_E : nmls_pkg::CH_UP_E,
                          1'b0, 1'b0, 1'b1);
                case ($urandom_range(0, 2))
                    0: push_char(nmls_pkg::CH_PLUS, 1'b0, 1'b0, 1'b1);
                    1: push_char(nmls_pkg::CH_MINUS, 1'b0, 1'b0, 1'b1);
                    default: ;
                endcase
                n = $urandom_range(0, 3);
                for (i = 0; i < n; i++) push_char(dec_char(), 1'b0, 1'b0, 1'b1);
            end
            if ($urandom_range(0, 1) != 0) push_char(nmls_pkg::CH_LO_F, 1'b0, 1'b0, 1'b1);
        end else if (pick < 78) begin
            s = boundary_text[$urandom_range(0, 10)];
            if ($urandom_range(0, 2) == 0) s.putc(s.len() - 1, dec_char());
            send_text(s);
            if ($urandom_range(0, 3) == 0) push_char(nmls_pkg::CH_LO_L, 1'b0, 1'b0, 1'b1);
        end else if (pick < 79) begin
            // run past the length cap
            push_char(dec_char(), 1'b0, 1'b1, 1'b1);
            if ($urandom_range(0, 1) != 0) push_char(nmls_pkg::CH_DOT, 1'b0, 1'b0, 1'b1);
            n = $urandom_range(256, 300);
            for (i = 0; i < n; i++) push_char(dec_char(), 1'b0, 1'b0, 1'b1);
        end else begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) begin
                push_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                          $urandom_range(0, 7) == 0, 1'b1);
            end
        end
        case ($urandom_range(0, 2))
            0: ;
            1: push_char(8'($urandom_range(0, 255)), 1'b1, $urandom_range(0, 3) == 0, 1'b1);
            default: push_char(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1);
        endcase
    endtask

    initial begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_text("0x");
        push_char(8'h00, 1'b1, 1'b0, 1'b1);
        send_text("7l");
        send_text("1.5f");
        push_char("A", 1'b1, 1'b0, 1'b1);
        push_char("a", 1'b0, 1'b1, 1'b1);
        push_char("9", 1'b0, 1'b1, 1'b1);
        push_char(8'hFF, 1'b1, 1'b1, 1'b1);
        send_text("3E-");
        send_text("0Xa");
        push_char(8'hFF, 1'b0, 1'b0, 1'b1);
        send_text("5e");
        push_char("f", 1'b0, 1'b0, 1'b1);
        drain_results();

        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= HOLD_AT && !hold_off_go) begin
                hold_off_go = 1'b1;
            end
            if (items_sent >= PAUSE_AT && !paused) begin
                paused = 1'b1;
                drain_results();
                send_literal(78);
            end
            if (items_sent >= CALM_FROM) begin
                calm = 1'b1;
            end
            send_literal($urandom_range(0, 99));
        end
        // flush any open token
        push_char(8'h00, 1'b1, 1'b0, 1'b1);
        drain_results();
        repeat (8) @(posedge clk);

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/nmls_pkg.sv
rtl/core/number_literal_scanner.sv
tb/number_literal_scanner_monitor.sv
tb/number_literal_scanner_test.sv
